/* rtl/i2cras_pkg.sv */
// shared types and codes for the i2c register access sequencer
package i2cras_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_TICK  = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        EV_START_DONE = 3'd0,
        EV_ADDR_ACK   = 3'd1,
        EV_BYTE_SENT  = 3'd2,
        EV_BYTE_RCVD  = 3'd3,
        EV_NACK       = 3'd4
    } bus_event_t;

    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_SEND  = 3'd1,
        ACT_RACK  = 3'd2,
        ACT_RNACK = 3'd3,
        ACT_STOP  = 3'd4,
        ACT_READ  = 3'd5,
        ACT_DONE  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NACK    = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_BADLEN  = 2'd3
    } status_t;

    localparam int unsigned MAX_RESULTS = 3;
    localparam logic [31:0] WAIT_LIMIT_RESET = 32'd100000;

    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  device_address;
        logic [7:0]  register_address;
        logic [7:0]  write_data;
        logic [15:0] read_length;
        logic [2:0]  bus_event;
        logic [7:0]  received_byte;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } res_word_t;

endpackage

/* rtl/i2c_register_access_sequencer.sv */
// i2c register access sequencer: command/event decode and result queue
//
// cmd channel: a word is a write or burst read request, a bus event from the
// byte-level engine, or a timing tick. res channel: the actions the engine
// must perform (start, send, receive with ack/nack, stop), read data and a
// finished word carrying the status. each command word yields 0 to 3 result
// words; the final one has last set.
// a command word is held in an input register, then decoded combinationally
// into a bundle of up to three results held in a shift register that drains
// one word per cycle while res_ready is high; the bundle is registered behind
// the input register. a word with k results holds the result port for k words;
// a new command is taken every cycle as long as each yields at most one result
// and res_ready stays high. when the receiver stalls the bundle holds, the input
// register fills and cmd_ready drops. wait_limit is written through
// wait_limit_we/wait_limit_data; the user must do so only while the block is
// idle, the block does not enforce it. reset empties both registers, puts the
// sequencer in idle and loads wait_limit with 100000.
module i2c_register_access_sequencer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wait_limit_we,
    input  logic [31:0]             wait_limit_data,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  i2cras_pkg::cmd_word_t   cmd_word,
    output logic                    res_valid,
    input  logic                    res_ready,
    output i2cras_pkg::res_word_t   res_word
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_WSTART = 4'd1,
        PH_WADDR  = 4'd2,
        PH_REG    = 4'd3,
        PH_DATA   = 4'd4,
        PH_RSTART = 4'd5,
        PH_RADDR  = 4'd6,
        PH_RECV   = 4'd7
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   is_read_reg, is_read_next;
    logic [6:0]             dev_reg, dev_next;
    logic [7:0]             regaddr_reg, regaddr_next;
    logic [7:0]             data_reg, data_next;
    logic [15:0]            len_reg, len_next;
    logic [15:0]            idx_reg, idx_next;
    logic [31:0]            wait_reg, wait_next;
    logic [31:0]            limit_reg;

    logic                   in_valid_reg;
    i2cras_pkg::cmd_word_t  in_reg;

    i2cras_pkg::res_word_t  res_reg [i2cras_pkg::MAX_RESULTS];
    logic [1:0]             rem_reg;

    i2cras_pkg::res_word_t  bnd [i2cras_pkg::MAX_RESULTS];
    logic [1:0]             bnd_cnt;
    logic                   slot_free;
    logic                   consume;
    logic [16:0]            idx_inc;
    logic [16:0]            len_m1;

    assign res_valid = (rem_reg != 2'd0);
    assign res_word  = res_reg[0];
    assign slot_free = (rem_reg == 2'd0) || (rem_reg == 2'd1 && res_ready);
    assign consume   = in_valid_reg && slot_free;
    assign cmd_ready = !in_valid_reg || consume;

    assign idx_inc = {1'b0, idx_reg} + 17'd1;
    assign len_m1  = {1'b0, len_reg} - 17'd1;

    // decode one command word into next state and a result bundle
    always_comb
    begin
        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        data_next    = data_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        wait_next    = wait_reg;
        bnd_cnt      = 2'd0;
        for (int i = 0; i < i2cras_pkg::MAX_RESULTS; i++)
        begin
            bnd[i] = '0;
        end

        unique case (in_reg.command)
            i2cras_pkg::CMD_WRITE, i2cras_pkg::CMD_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (in_reg.command == i2cras_pkg::CMD_READ && in_reg.read_length == 16'd0)
                    begin
                        bnd[0].action = i2cras_pkg::ACT_DONE;
                        bnd[0].status = i2cras_pkg::ST_BADLEN;
                        bnd_cnt       = 2'd1;
                        wait_next     = '0;
                    end
                    else
                    begin
                        is_read_next = (in_reg.command == i2cras_pkg::CMD_READ);
                        dev_next     = in_reg.device_address;
                        regaddr_next = in_reg.register_address;
                        data_next    = in_reg.write_data;
                        len_next     = (in_reg.command == i2cras_pkg::CMD_READ)
                                       ? in_reg.read_length : 16'd0;
                        idx_next     = '0;
                        wait_next    = '0;
                        bnd[0].action = i2cras_pkg::ACT_START;
                        bnd_cnt      = 2'd1;
                        phase_next   = PH_WSTART;
                    end
                end
            end
            i2cras_pkg::CMD_EVENT:
            begin
                if (in_reg.bus_event == i2cras_pkg::EV_NACK)
                begin
                    unique case (phase_reg)
                        PH_WSTART, PH_RSTART, PH_RECV:
                        begin
                            bnd[0].action = i2cras_pkg::ACT_DONE;
                            bnd[0].status = i2cras_pkg::ST_NACK;
                            bnd_cnt       = 2'd1;
                            phase_next    = PH_IDLE;
                            wait_next     = '0;
                        end
                        PH_WADDR, PH_REG, PH_DATA, PH_RADDR:
                        begin
                            bnd[0].action = i2cras_pkg::ACT_STOP;
                            bnd[1].action = i2cras_pkg::ACT_DONE;
                            bnd[1].status = i2cras_pkg::ST_NACK;
                            bnd_cnt       = 2'd2;
                            phase_next    = PH_IDLE;
                            wait_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (phase_reg == PH_WSTART && in_reg.bus_event == i2cras_pkg::EV_START_DONE)
                begin
                    bnd[0].action   = i2cras_pkg::ACT_SEND;
                    bnd[0].out_byte = {dev_reg, 1'b0};
                    bnd_cnt         = 2'd1;
                    phase_next      = PH_WADDR;
                    wait_next       = '0;
                end
                else if (phase_reg == PH_WADDR && in_reg.bus_event == i2cras_pkg::EV_ADDR_ACK)
                begin
                    bnd[0].action   = i2cras_pkg::ACT_SEND;
                    bnd[0].out_byte = regaddr_reg;
                    bnd_cnt         = 2'd1;
                    phase_next      = PH_REG;
                    wait_next       = '0;
                end
                else if (phase_reg == PH_REG && in_reg.bus_event == i2cras_pkg::EV_BYTE_SENT)
                begin
                    bnd_cnt   = 2'd1;
                    wait_next = '0;
                    if (is_read_reg)
                    begin
                        bnd[0].action = i2cras_pkg::ACT_START;
                        phase_next    = PH_RSTART;
                    end
                    else
                    begin
                        bnd[0].action   = i2cras_pkg::ACT_SEND;
                        bnd[0].out_byte = data_reg;
                        phase_next      = PH_DATA;
                    end
                end
                else if (phase_reg == PH_DATA && in_reg.bus_event == i2cras_pkg::EV_BYTE_SENT)
                begin
                    bnd[0].action = i2cras_pkg::ACT_STOP;
                    bnd[1].action = i2cras_pkg::ACT_DONE;
                    bnd[1].status = i2cras_pkg::ST_OK;
                    bnd_cnt       = 2'd2;
                    phase_next    = PH_IDLE;
                    wait_next     = '0;
                end
                else if (phase_reg == PH_RSTART && in_reg.bus_event == i2cras_pkg::EV_START_DONE)
                begin
                    bnd[0].action   = i2cras_pkg::ACT_SEND;
                    bnd[0].out_byte = {dev_reg, 1'b1};
                    bnd_cnt         = 2'd1;
                    phase_next      = PH_RADDR;
                    wait_next       = '0;
                end
                else if (phase_reg == PH_RADDR && in_reg.bus_event == i2cras_pkg::EV_ADDR_ACK)
                begin
                    if (len_reg == 16'd1)
                    begin
                        bnd[0].action = i2cras_pkg::ACT_RNACK;
                        bnd[1].action = i2cras_pkg::ACT_STOP;
                        bnd_cnt       = 2'd2;
                    end
                    else
                    begin
                        bnd[0].action = i2cras_pkg::ACT_RACK;
                        bnd_cnt       = 2'd1;
                    end
                    idx_next   = '0;
                    phase_next = PH_RECV;
                    wait_next  = '0;
                end
                else if (phase_reg == PH_RECV && in_reg.bus_event == i2cras_pkg::EV_BYTE_RCVD)
                begin
                    bnd[0].action   = i2cras_pkg::ACT_READ;
                    bnd[0].out_byte = in_reg.received_byte;
                    idx_next        = idx_inc[15:0];
                    wait_next       = '0;
                    if (idx_inc >= {1'b0, len_reg})
                    begin
                        bnd[1].action = i2cras_pkg::ACT_DONE;
                        bnd[1].status = i2cras_pkg::ST_OK;
                        bnd_cnt       = 2'd2;
                        phase_next    = PH_IDLE;
                    end
                    else if (idx_inc == len_m1)
                    begin
                        bnd[1].action = i2cras_pkg::ACT_RNACK;
                        bnd[2].action = i2cras_pkg::ACT_STOP;
                        bnd_cnt       = 2'd3;
                    end
                    else
                    begin
                        bnd[1].action = i2cras_pkg::ACT_RACK;
                        bnd_cnt       = 2'd2;
                    end
                end
            end
            i2cras_pkg::CMD_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (wait_reg >= limit_reg)
                    begin
                        bnd[0].action = i2cras_pkg::ACT_DONE;
                        bnd[0].status = i2cras_pkg::ST_TIMEOUT;
                        bnd_cnt       = 2'd1;
                        phase_next    = PH_IDLE;
                        wait_next     = '0;
                    end
                    else
                    begin
                        wait_next = wait_reg + 32'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < i2cras_pkg::MAX_RESULTS; i++)
        begin
            bnd[i].last = (bnd_cnt == 2'(i + 1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            is_read_reg  <= 1'b0;
            dev_reg      <= '0;
            regaddr_reg  <= '0;
            data_reg     <= '0;
            len_reg      <= '0;
            idx_reg      <= '0;
            wait_reg     <= '0;
            limit_reg    <= i2cras_pkg::WAIT_LIMIT_RESET;
            in_valid_reg <= 1'b0;
            rem_reg      <= 2'd0;
        end
        else
        begin
            if (wait_limit_we)
            begin
                limit_reg <= wait_limit_data;
            end
            if (cmd_ready)
            begin
                in_valid_reg <= cmd_valid;
            end
            if (consume)
            begin
                phase_reg   <= phase_next;
                is_read_reg <= is_read_next;
                dev_reg     <= dev_next;
                regaddr_reg <= regaddr_next;
                data_reg    <= data_next;
                len_reg     <= len_next;
                idx_reg     <= idx_next;
                wait_reg    <= wait_next;
                rem_reg     <= bnd_cnt;
            end
            else if (res_valid && res_ready)
            begin
                rem_reg <= rem_reg - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            in_reg <= cmd_word;
        end
        if (consume)
        begin
            for (int i = 0; i < i2cras_pkg::MAX_RESULTS; i++)
            begin
                res_reg[i] <= bnd[i];
            end
        end
        else if (res_valid && res_ready)
        begin
            for (int i = 0; i < i2cras_pkg::MAX_RESULTS - 1; i++)
            begin
                res_reg[i] <= res_reg[i + 1];
            end
        end
    end

endmodule

/* rtl/i2cras_checker.sv */
// port-level checks for the i2c register access sequencer, bound to the top level
module i2cras_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    res_valid,
    input  logic                    res_ready,
    input  i2cras_pkg::res_word_t   res_word
);

    // a held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // the rest of a bundle follows without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_word.last |=> res_valid)
        else $error("bundle interrupted before last word");

    // status only on finished words
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.action != i2cras_pkg::ACT_DONE |-> res_word.status == 2'd0)
        else $error("status set on non-finished word");

    // a finished word always closes its bundle with no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.action == i2cras_pkg::ACT_DONE
        |-> res_word.last && res_word.out_byte == 8'd0)
        else $error("finished word malformed");

endmodule

bind i2c_register_access_sequencer i2cras_checker u_i2cras_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
);

/* dv/i2c_register_access_sequencer_tb.sv */
// testbench for the i2c register access sequencer: directed table, then adaptive random traffic
module i2c_register_access_sequencer_tb;

    typedef enum logic [3:0] {
        SEQ_IDLE   = 4'd0,
        SEQ_WSTART = 4'd1,
        SEQ_WADDR  = 4'd2,
        SEQ_REG    = 4'd3,
        SEQ_DATA   = 4'd4,
        SEQ_RSTART = 4'd5,
        SEQ_RADDR  = 4'd6,
        SEQ_RECV   = 4'd7
    } seq_phase_t;

    localparam logic [2:0] EV_RESERVED = 3'd7;

    typedef struct packed {
        seq_phase_t  phase;
        logic        rd;
        logic [6:0]  dev;
        logic [7:0]  regaddr;
        logic [7:0]  data;
        logic [15:0] blen;
        logic [15:0] idx;
        logic [31:0] waited;
        logic [31:0] limit;
    } seq_state_t;

    typedef struct packed {
        i2cras_pkg::cmd_word_t       word;
        logic                        typed;
        logic [1:0]                  n_typed;
        i2cras_pkg::res_word_t [1:0] fixed;
    } stim_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wait_limit_we = 1'b0;
    logic [31:0]           wait_limit_data = '0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    i2cras_pkg::cmd_word_t cmd_word = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    i2cras_pkg::res_word_t res_word;

    seq_state_t            tracked;
    seq_state_t            planned;
    stim_t                 cmd_plan[$];
    stim_t                 cur_row;
    i2cras_pkg::res_word_t pending_actions[$];
    int                    mismatches = 0;
    bit                    hold_request = 1'b0;

    i2c_register_access_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .wait_limit_we   (wait_limit_we),
        .wait_limit_data (wait_limit_data),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd_word        (cmd_word),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_word        (res_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic i2cras_pkg::res_word_t mk(i2cras_pkg::action_t act,
                                                 logic [7:0] value,
                                                 i2cras_pkg::status_t st);
        i2cras_pkg::res_word_t r;
        r.action = act;
        r.out_byte = value;
        r.status = st;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void sequence_step(inout seq_state_t s,
                                          input i2cras_pkg::cmd_word_t w,
                                          output i2cras_pkg::res_word_t [2:0] r,
                                          output int n);
        logic [16:0]         nxt;
        logic [32:0]         waited_next;
        bit                  fin;
        bit                  moved;
        i2cras_pkg::status_t fin_st;
        r = '0;
        n = 0;
        fin = 1'b0;
        moved = 1'b0;
        fin_st = i2cras_pkg::ST_OK;
        case (w.command)
            i2cras_pkg::CMD_WRITE, i2cras_pkg::CMD_READ:
            begin
                if (s.phase == SEQ_IDLE)
                begin
                    if (w.command == i2cras_pkg::CMD_READ && w.read_length == '0)
                    begin
                        fin = 1'b1;
                        fin_st = i2cras_pkg::ST_BADLEN;
                    end
                    else
                    begin
                        s.rd = (w.command == i2cras_pkg::CMD_READ);
                        s.dev = w.device_address;
                        s.regaddr = w.register_address;
                        s.data = w.write_data;
                        s.blen = s.rd ? w.read_length : 16'd0;
                        s.idx = '0;
                        s.waited = '0;
                        r[n] = mk(i2cras_pkg::ACT_START, 8'h00, i2cras_pkg::ST_OK);
                        n++;
                        s.phase = SEQ_WSTART;
                    end
                end
            end
            i2cras_pkg::CMD_EVENT:
            begin
                if (w.bus_event == i2cras_pkg::EV_NACK)
                begin
                    case (s.phase)
                        SEQ_WSTART, SEQ_RSTART, SEQ_RECV: fin = 1'b1;
                        SEQ_WADDR, SEQ_REG, SEQ_DATA, SEQ_RADDR:
                        begin
                            r[n] = mk(i2cras_pkg::ACT_STOP, 8'h00, i2cras_pkg::ST_OK);
                            n++;
                            fin = 1'b1;
                        end
                        default: ;
                    endcase
                    fin_st = i2cras_pkg::ST_NACK;
                end
                else
                begin
                    moved = 1'b1;
                    if (s.phase == SEQ_WSTART && w.bus_event == i2cras_pkg::EV_START_DONE)
                    begin
                        r[n] = mk(i2cras_pkg::ACT_SEND, {s.dev, 1'b0}, i2cras_pkg::ST_OK);
                        n++;
                        s.phase = SEQ_WADDR;
                    end
                    else if (s.phase == SEQ_WADDR && w.bus_event == i2cras_pkg::EV_ADDR_ACK)
                    begin
                        r[n] = mk(i2cras_pkg::ACT_SEND, s.regaddr, i2cras_pkg::ST_OK);
                        n++;
                        s.phase = SEQ_REG;
                    end
                    else if (s.phase == SEQ_REG && w.bus_event == i2cras_pkg::EV_BYTE_SENT)
                    begin
                        if (s.rd)
                        begin
                            r[n] = mk(i2cras_pkg::ACT_START, 8'h00, i2cras_pkg::ST_OK);
                            s.phase = SEQ_RSTART;
                        end
                        else
                        begin
                            r[n] = mk(i2cras_pkg::ACT_SEND, s.data, i2cras_pkg::ST_OK);
                            s.phase = SEQ_DATA;
                        end
                        n++;
                    end
                    else if (s.phase == SEQ_DATA && w.bus_event == i2cras_pkg::EV_BYTE_SENT)
                    begin
                        r[n] = mk(i2cras_pkg::ACT_STOP, 8'h00, i2cras_pkg::ST_OK);
                        n++;
                        fin = 1'b1;
                    end
                    else if (s.phase == SEQ_RSTART && w.bus_event == i2cras_pkg::EV_START_DONE)
                    begin
                        r[n] = mk(i2cras_pkg::ACT_SEND, {s.dev, 1'b1}, i2cras_pkg::ST_OK);
                        n++;
                        s.phase = SEQ_RADDR;
                    end
                    else if (s.phase == SEQ_RADDR && w.bus_event == i2cras_pkg::EV_ADDR_ACK)
                    begin
                        if (s.blen == 16'd1)
                        begin
                            r[n] = mk(i2cras_pkg::ACT_RNACK, 8'h00, i2cras_pkg::ST_OK);
                            r[n + 1] = mk(i2cras_pkg::ACT_STOP, 8'h00, i2cras_pkg::ST_OK);
                            n += 2;
                        end
                        else
                        begin
                            r[n] = mk(i2cras_pkg::ACT_RACK, 8'h00, i2cras_pkg::ST_OK);
                            n++;
                        end
                        s.idx = '0;
                        s.phase = SEQ_RECV;
                    end
                    else if (s.phase == SEQ_RECV && w.bus_event == i2cras_pkg::EV_BYTE_RCVD)
                    begin
                        nxt = {1'b0, s.idx} + 17'd1;
                        r[n] = mk(i2cras_pkg::ACT_READ, w.received_byte, i2cras_pkg::ST_OK);
                        n++;
                        s.idx = nxt[15:0];
                        if (nxt >= {1'b0, s.blen})
                            fin = 1'b1;
                        else if (nxt == {1'b0, s.blen} - 17'd1)
                        begin
                            r[n] = mk(i2cras_pkg::ACT_RNACK, 8'h00, i2cras_pkg::ST_OK);
                            r[n + 1] = mk(i2cras_pkg::ACT_STOP, 8'h00, i2cras_pkg::ST_OK);
                            n += 2;
                        end
                        else
                        begin
                            r[n] = mk(i2cras_pkg::ACT_RACK, 8'h00, i2cras_pkg::ST_OK);
                            n++;
                        end
                    end
                    else
                        moved = 1'b0;
                    if (moved)
                        s.waited = '0;
                end
            end
            default:
            begin
                if (s.phase != SEQ_IDLE)
                begin
                    waited_next = {1'b0, s.waited} + 33'd1;
                    if (waited_next > {1'b0, s.limit})
                    begin
                        fin = 1'b1;
                        fin_st = i2cras_pkg::ST_TIMEOUT;
                    end
                    else
                        s.waited = waited_next[31:0];
                end
            end
        endcase
        if (fin)
        begin
            r[n] = mk(i2cras_pkg::ACT_DONE, 8'h00, fin_st);
            n++;
            s.phase = SEQ_IDLE;
            s.waited = '0;
        end
        if (n > 0)
            r[n - 1].last = 1'b1;
    endfunction

    function automatic i2cras_pkg::cmd_word_t req(i2cras_pkg::command_t c, logic [6:0] dev,
                                                  logic [7:0] ra, logic [7:0] wd,
                                                  logic [15:0] len);
        i2cras_pkg::cmd_word_t w;
        w = '0;
        w.command = c;
        w.device_address = dev;
        w.register_address = ra;
        w.write_data = wd;
        w.read_length = len;
        return w;
    endfunction

    function automatic i2cras_pkg::cmd_word_t evt(logic [2:0] ev, logic [7:0] rx);
        i2cras_pkg::cmd_word_t w;
        w = '0;
        w.command = i2cras_pkg::CMD_EVENT;
        w.bus_event = ev;
        w.received_byte = rx;
        return w;
    endfunction

    function automatic void add_row(i2cras_pkg::cmd_word_t w, bit typed, int n,
                                    i2cras_pkg::res_word_t e0 = '0,
                                    i2cras_pkg::res_word_t e1 = '0);
        stim_t s;
        if (n == 1)
            e0.last = 1'b1;
        if (n == 2)
            e1.last = 1'b1;
        s.word = w;
        s.typed = typed;
        s.n_typed = n[1:0];
        s.fixed = {e1, e0};
        cmd_plan.push_back(s);
    endfunction

    // mostly the event the sequencer waits for, plus ticks, nacks and stray words
    function automatic i2cras_pkg::cmd_word_t plan_word(input seq_state_t g, input int tick_pct,
                                                        output bit noise);
        i2cras_pkg::cmd_word_t w;
        logic [63:0]           raw;
        int unsigned           roll;
        raw = {$urandom, $urandom};
        w = raw[$bits(i2cras_pkg::cmd_word_t)-1:0];
        roll = $urandom_range(0, 99);
        noise = 1'b0;
        if (g.phase == SEQ_IDLE)
        begin
            if (roll < 44)
                w.command = i2cras_pkg::CMD_WRITE;
            else if (roll < 88)
            begin
                w.command = i2cras_pkg::CMD_READ;
                case ($urandom_range(0, 19))
                    0: w.read_length = 16'hffff;
                    1: w.read_length = 16'($urandom_range(1, 65535));
                    2, 3: w.read_length = 16'($urandom_range(5, 16));
                    default: w.read_length = 16'($urandom_range(1, 4));
                endcase
            end
            else if (roll < 91)
            begin
                w.command = i2cras_pkg::CMD_READ;
                w.read_length = '0;
            end
            else
            begin
                noise = 1'b1;
                w.command = (roll < 95) ? i2cras_pkg::CMD_TICK : i2cras_pkg::CMD_EVENT;
            end
        end
        else if (roll < tick_pct)
            w.command = i2cras_pkg::CMD_TICK;
        else if (roll < tick_pct + 4)
        begin
            w.command = i2cras_pkg::CMD_EVENT;
            w.bus_event = i2cras_pkg::EV_NACK;
        end
        else if (roll < tick_pct + 9)
        begin
            noise = 1'b1;
            w.command = i2cras_pkg::CMD_EVENT;
        end
        else if (roll < tick_pct + 13)
        begin
            noise = 1'b1;
            w.command = roll[0] ? i2cras_pkg::CMD_WRITE : i2cras_pkg::CMD_READ;
        end
        else
        begin
            w.command = i2cras_pkg::CMD_EVENT;
            case (g.phase)
                SEQ_WSTART, SEQ_RSTART: w.bus_event = i2cras_pkg::EV_START_DONE;
                SEQ_WADDR, SEQ_RADDR: w.bus_event = i2cras_pkg::EV_ADDR_ACK;
                SEQ_REG, SEQ_DATA: w.bus_event = i2cras_pkg::EV_BYTE_SENT;
                default: w.bus_event = i2cras_pkg::EV_BYTE_RCVD;
            endcase
        end
        return w;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        i2cras_pkg::res_word_t       want;
        i2cras_pkg::res_word_t [2:0] produced;
        int                          count;
        if (rst_n && cmd_valid && cmd_ready)
        begin
            sequence_step(tracked, cmd_word, produced, count);
            if (cur_row.typed)
            begin
                for (int i = 0; i < int'(cur_row.n_typed); i++)
                    pending_actions.push_back(cur_row.fixed[i]);
            end
            else
            begin
                for (int i = 0; i < count; i++)
                    pending_actions.push_back(produced[i]);
            end
        end
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_actions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: act %0d byte %02h st %0d last %0b",
                             res_word.action, res_word.out_byte, res_word.status,
                             res_word.last);
            end
            else
            begin
                want = pending_actions.pop_front();
                if (res_word.action !== want.action || res_word.out_byte !== want.out_byte ||
                    res_word.status !== want.status || res_word.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: want act %0d byte %02h st %0d last %0b,",
                                 want.action, want.out_byte, want.status, want.last);
                        $display("  got act %0d byte %02h st %0d last %0b",
                                 res_word.action, res_word.out_byte, res_word.status,
                                 res_word.last);
                    end
                end
            end
        end
    end

    initial
    begin : result_sink
        int   stretch;
        logic level;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                level = 1'b0;
                stretch = 80;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        level = 1'b1;
                        stretch = $urandom_range(8, 20);
                    end
                    1:
                    begin
                        level = 1'b0;
                        stretch = $urandom_range(1, 4);
                    end
                    2:
                    begin
                        level = 1'b1;
                        stretch = $urandom_range(1, 3);
                    end
                    default:
                    begin
                        level = 1'b0;
                        stretch = 1;
                    end
                endcase
            end
            repeat (stretch)
            begin
                @(negedge clk);
                res_ready <= level;
            end
        end
    end

    task automatic send_items(input bit gaps);
        stim_t row;
        int    burst;
        int    bursts;
        burst = 0;
        bursts = 0;
        while (cmd_plan.size() > 0)
        begin
            if (gaps && burst <= 0)
            begin
                cmd_valid <= 1'b0;
                bursts++;
                if (bursts % 6 == 0)
                begin
                    while (pending_actions.size() != 0)
                        @(posedge clk);
                    @(negedge clk);
                end
                else
                    repeat ($urandom_range(1, 8)) @(negedge clk);
                burst = $urandom_range(1, 24);
            end
            row = cmd_plan.pop_front();
            cur_row = row;
            cmd_valid <= 1'b1;
            cmd_word <= row.word;
            @(posedge clk);
            while (!cmd_ready)
                @(posedge clk);
            @(negedge clk);
            burst--;
        end
        cmd_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_actions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [31:0] limit, input int items, input int tick_pct,
                             input bit gaps, input bit hold);
        i2cras_pkg::cmd_word_t       w;
        i2cras_pkg::res_word_t [2:0] scratch;
        int                          k;
        int                          made;
        bit                          noise;
        @(negedge clk);
        wait_limit_we <= 1'b1;
        wait_limit_data <= limit;
        @(negedge clk);
        wait_limit_we <= 1'b0;
        tracked.limit = limit;
        planned = tracked;
        made = 0;
        while (made < items)
        begin
            w = plan_word(planned, tick_pct, noise);
            sequence_step(planned, w, scratch, k);
            add_row(w, 1'b0, 0);
            if (!noise)
                made++;
        end
        if (hold)
            hold_request = 1'b1;
        send_items(gaps);
        settle();
    endtask

    initial
    begin : stimulus
        tracked = '0;
        tracked.limit = i2cras_pkg::WAIT_LIMIT_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_row(req(i2cras_pkg::CMD_TICK, 7'h00, 8'h00, 8'h00, 16'd0), 1'b1, 0);
        add_row(evt(i2cras_pkg::EV_START_DONE, 8'h00), 1'b1, 0);
        add_row(req(i2cras_pkg::CMD_READ, 7'h7f, 8'hff, 8'hff, 16'd0), 1'b1, 1,
                mk(i2cras_pkg::ACT_DONE, 8'h00, i2cras_pkg::ST_BADLEN));
        add_row(req(i2cras_pkg::CMD_WRITE, 7'h7f, 8'hff, 8'h00, 16'hffff), 1'b1, 1,
                mk(i2cras_pkg::ACT_START, 8'h00, i2cras_pkg::ST_OK));
        add_row(req(i2cras_pkg::CMD_READ, 7'h01, 8'h01, 8'h01, 16'd1), 1'b1, 0);
        add_row(req(i2cras_pkg::CMD_TICK, 7'h00, 8'h00, 8'h00, 16'd0), 1'b1, 0);
        add_row(evt(i2cras_pkg::EV_START_DONE, 8'h00), 1'b1, 1,
                mk(i2cras_pkg::ACT_SEND, 8'hfe, i2cras_pkg::ST_OK));
        add_row(evt(EV_RESERVED, 8'hff), 1'b1, 0);
        add_row(evt(i2cras_pkg::EV_ADDR_ACK, 8'h00), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_BYTE_SENT, 8'h00), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_BYTE_SENT, 8'h00), 1'b1, 2,
                mk(i2cras_pkg::ACT_STOP, 8'h00, i2cras_pkg::ST_OK),
                mk(i2cras_pkg::ACT_DONE, 8'h00, i2cras_pkg::ST_OK));
        // single byte read: nack and stop right after the address ack
        add_row(req(i2cras_pkg::CMD_READ, 7'h00, 8'h80, 8'h00, 16'd1), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_START_DONE, 8'h00), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_ADDR_ACK, 8'h00), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_BYTE_SENT, 8'h00), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_START_DONE, 8'h00), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_ADDR_ACK, 8'h00), 1'b1, 2,
                mk(i2cras_pkg::ACT_RNACK, 8'h00, i2cras_pkg::ST_OK),
                mk(i2cras_pkg::ACT_STOP, 8'h00, i2cras_pkg::ST_OK));
        add_row(evt(i2cras_pkg::EV_BYTE_RCVD, 8'ha5), 1'b1, 2,
                mk(i2cras_pkg::ACT_READ, 8'ha5, i2cras_pkg::ST_OK),
                mk(i2cras_pkg::ACT_DONE, 8'h00, i2cras_pkg::ST_OK));
        // nack while waiting for start, then nack on the address
        add_row(req(i2cras_pkg::CMD_READ, 7'h55, 8'haa, 8'h55, 16'hffff), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_NACK, 8'h00), 1'b1, 1,
                mk(i2cras_pkg::ACT_DONE, 8'h00, i2cras_pkg::ST_NACK));
        add_row(req(i2cras_pkg::CMD_WRITE, 7'h2a, 8'h0f, 8'hff, 16'h0000), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_START_DONE, 8'h00), 1'b0, 0);
        add_row(evt(i2cras_pkg::EV_NACK, 8'h00), 1'b1, 2,
                mk(i2cras_pkg::ACT_STOP, 8'h00, i2cras_pkg::ST_OK),
                mk(i2cras_pkg::ACT_DONE, 8'h00, i2cras_pkg::ST_NACK));
        send_items(1'b1);
        settle();

        run_phase(32'hffff_ffff, 40, 10, 1'b1, 1'b0);
        run_phase(32'd2, 40, 25, 1'b1, 1'b0);
        run_phase(32'd1, 30, 25, 1'b1, 1'b0);
        run_phase(32'd0, 20, 10, 1'b1, 1'b0);
        run_phase(i2cras_pkg::WAIT_LIMIT_RESET, 50, 10, 1'b0, 1'b1);
        run_phase(32'd5, 35, 30, 1'b1, 1'b0);

        if (mismatches == 0 && pending_actions.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/i2cras_pkg.sv
rtl/i2c_register_access_sequencer.sv
rtl/i2cras_checker.sv
dv/i2c_register_access_sequencer_tb.sv
